// ----- sv/bpfa_pkg.sv -----
// Shared types and constants of the bitmap page frame allocator.
`default_nettype none

package bpfa_pkg;

    localparam int ADDR_W  = 48;  // physical byte address
    localparam int COUNT_W = 11;  // page_count register
    localparam int WORD_W  = 32;  // bitmap word, one bit per page
    localparam int WBIT_W  = 5;   // bit position within a bitmap word

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_REGION_BASE = 1'b0,
        CFG_PAGE_COUNT  = 1'b1
    } cfg_index_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_BADADDR = 2'd2
    } status_t;

    // Request kinds
    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    clr_start;   // restart the bitmap clearing sweep
        logic    clr_run;     // write one bitmap word of the sweep
        logic    load_req;    // capture the input beat, reset the result
        logic    scan_start;  // rewind the first-fit scan
        logic    scan_run;    // read one word, check the previous one
        logic    a_mul;       // page index times page size
        logic    a_add;       // add region base
        logic    f_sub;       // offset of the free address from the base
        logic    div_start;   // multiply the offset by the page size reciprocal
        logic    div_run;     // take the page index from the product
        logic    f_rd;        // read the word of the page being freed
        logic    f_wr;        // write it back with the page bit cleared
        logic    set_status;  // overwrite the pending status
        status_t status;
        logic    out_load;    // move the result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pc_write;   // page_count is being written
        logic clr_last;   // sweep is at its last word
        logic scan_hit;   // free page found in the checked word
        logic scan_miss;  // no free page left among the managed ones
        logic bad_addr;   // free address outside the region
        logic div_last;   // page index ready
        logic out_free;   // output register can take a result
    } sts_t;

endpackage

`default_nettype wire

// ----- sv/bpfa_dp.sv -----
// Datapath of the bitmap page frame allocator: registers, bitmap memory, divider, output stage.
`default_nettype none

module bpfa_dp #(
    parameter int MAX_PAGES  = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire bpfa_pkg::cmd_t              cmd,
    output bpfa_pkg::sts_t                   sts,
    input  wire logic [bpfa_pkg::ADDR_W-1:0] s_tdata,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [bpfa_pkg::ADDR_W-1:0] cfg_data,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [bpfa_pkg::ADDR_W-1:0]      m_tdata,
    output logic [1:0]                       m_tuser
);

    localparam int AW        = bpfa_pkg::ADDR_W;
    localparam int WW        = bpfa_pkg::WORD_W;
    localparam int BW        = bpfa_pkg::WBIT_W;
    localparam int CW        = bpfa_pkg::COUNT_W;
    localparam int NUM_WORDS = (MAX_PAGES + WW - 1) / WW;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int PI_W      = WA_W + BW;
    localparam int NW        = $clog2(MAX_PAGES + 1);
    localparam int SAT_W     = (CW > NW) ? CW : NW;
    localparam int PB_W      = $clog2(PAGE_BYTES + 1);
    localparam int LIM_W     = NW + PB_W;
    localparam int PROD_W    = PI_W + PB_W;
    localparam int SH        = LIM_W + PB_W;
    localparam int QP_W      = SH + PI_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);

    // configuration
    logic [AW-1:0]    base_reg;
    logic [NW-1:0]    n_reg;
    logic [NW-1:0]    n_next;
    logic [LIM_W-1:0] limit_reg;
    logic [SAT_W-1:0] pc_ext;
    logic             cfg_wr;

    // bitmap memory and its ports
    logic [WW-1:0]    bitmap_mem [NUM_WORDS];
    logic [WW-1:0]    rd_data_reg;
    logic             wen;
    logic [WA_W-1:0]  waddr;
    logic [WW-1:0]    wdata;
    logic             ren;
    logic [WA_W-1:0]  raddr;

    // sweep and scan
    logic [WA_W-1:0]  clr_ptr_reg;
    logic [WA_W-1:0]  rd_ptr_reg;
    logic [WA_W-1:0]  chk_word_reg;
    logic             chk_valid_reg;
    logic             n_zero;
    logic [NW-1:0]    nm1;
    logic [WA_W-1:0]  last_word;
    logic [BW-1:0]    tail;
    logic [WW-1:0]    tail_mask;
    logic [WW-1:0]    free_bits;
    logic             any_free;
    logic [BW-1:0]    hit_bit;
    logic             hit_wr;

    // allocate address
    logic [PI_W-1:0]   idx_reg;
    logic [PROD_W-1:0] prod_reg;

    // free path
    logic [AW-1:0]     addr_reg;
    logic [AW:0]       diff_reg;
    logic [QP_W-1:0]   recip_prod_reg;
    logic [PI_W-1:0]   q_reg;
    logic [WA_W-1:0]   f_word;
    logic [BW-1:0]     f_bit;

    // result and output stage
    bpfa_pkg::status_t res_status_reg;
    logic [AW-1:0]     res_addr_reg;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    bpfa_pkg::status_t m_status_reg;
    logic [AW-1:0]     m_addr_reg;

    // ---------------- configuration ----------------
    assign cfg_wr = cfg_valid && cfg_ready;
    assign pc_ext = SAT_W'(cfg_data[CW-1:0]);
    assign n_next = (pc_ext > SAT_W'(MAX_PAGES)) ? NW'(MAX_PAGES) : NW'(pc_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            n_reg     <= '0;
            limit_reg <= '0;
        end else begin
            if (cfg_wr && cfg_index == bpfa_pkg::CFG_REGION_BASE) begin
                base_reg <= cfg_data;
            end
            if (cfg_wr && cfg_index == bpfa_pkg::CFG_PAGE_COUNT) begin
                n_reg <= n_next;
            end
            limit_reg <= LIM_W'(n_reg) * LIM_W'(PAGE_BYTES);
        end
    end

    // ---------------- scan checks ----------------
    assign n_zero    = (n_reg == '0);
    assign nm1       = n_reg - NW'(1);
    assign last_word = WA_W'(nm1 >> BW);
    assign tail      = BW'(n_reg);
    assign tail_mask = (tail == '0) ? {WW{1'b1}} : ((WW'(1) << tail) - WW'(1));
    assign free_bits = ~rd_data_reg & ((chk_word_reg == last_word) ? tail_mask : {WW{1'b1}});
    assign any_free  = |free_bits;

    always_comb begin
        hit_bit = '0;
        for (int b = WW - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                hit_bit = BW'(b);
            end
        end
    end

    assign hit_wr = cmd.scan_run && sts.scan_hit;
    assign f_word = q_reg[PI_W-1:BW];
    assign f_bit  = q_reg[BW-1:0];

    // ---------------- memory ports ----------------
    always_comb begin
        wen   = 1'b0;
        waddr = clr_ptr_reg;
        wdata = '0;
        if (cmd.clr_run) begin
            // the bitmap itself fits in page zero whenever any page is managed
            wen   = 1'b1;
            waddr = clr_ptr_reg;
            wdata = (clr_ptr_reg == '0) ? {{(WW-1){1'b0}}, ~n_zero} : '0;
        end else if (hit_wr) begin
            wen   = 1'b1;
            waddr = chk_word_reg;
            wdata = rd_data_reg | (WW'(1) << hit_bit);
        end else if (cmd.f_wr) begin
            wen   = 1'b1;
            waddr = f_word;
            wdata = rd_data_reg & ~(WW'(1) << f_bit);
        end
    end

    assign ren   = cmd.scan_run || cmd.f_rd;
    assign raddr = cmd.scan_run ? rd_ptr_reg : f_word;

    always_ff @(posedge aclk) begin
        if (wen) begin
            bitmap_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ren) begin
            rd_data_reg <= bitmap_mem[raddr];
        end
    end

    // ---------------- sweep and scan pointers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg   <= '0;
            rd_ptr_reg    <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_start) begin
                clr_ptr_reg <= '0;
            end else if (cmd.clr_run && !sts.clr_last) begin
                clr_ptr_reg <= clr_ptr_reg + WA_W'(1);
            end
            if (cmd.scan_start) begin
                rd_ptr_reg    <= '0;
                chk_valid_reg <= 1'b0;
            end else if (cmd.scan_run) begin
                chk_valid_reg <= 1'b1;
                if (rd_ptr_reg != last_word) begin
                    rd_ptr_reg <= rd_ptr_reg + WA_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_run) begin
            chk_word_reg <= rd_ptr_reg;
        end
        if (hit_wr) begin
            idx_reg <= {chk_word_reg, hit_bit};
        end
        if (cmd.a_mul) begin
            prod_reg <= PROD_W'(idx_reg) * PROD_W'(PAGE_BYTES);
        end
    end

    // ---------------- free path: offset, bound, page index ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            addr_reg <= s_tdata;
        end
        if (cmd.f_sub) begin
            diff_reg <= {1'b0, addr_reg} - {1'b0, base_reg};
        end
    end

    // the offset lies below the region size here, so the rounded-up reciprocal
    // gives the exact truncated quotient
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            recip_prod_reg <= QP_W'(diff_reg[LIM_W-1:0]) * QP_W'(RECIP);
        end
        if (cmd.div_run) begin
            q_reg <= recip_prod_reg[SH +: PI_W];
        end
    end

    // ---------------- pending result ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            res_status_reg <= bpfa_pkg::ST_OK;
            res_addr_reg   <= '0;
        end else begin
            if (cmd.set_status) begin
                res_status_reg <= cmd.status;
            end
            if (cmd.a_add) begin
                res_addr_reg <= base_reg + AW'(prod_reg);
            end
        end
    end

    // ---------------- output register ----------------
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_addr_reg   <= res_addr_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_status_reg;

    // ---------------- status ----------------
    assign sts.pc_write  = cfg_wr && cfg_index == bpfa_pkg::CFG_PAGE_COUNT;
    assign sts.clr_last  = (clr_ptr_reg == WA_W'(NUM_WORDS - 1));
    assign sts.scan_hit  = !n_zero && chk_valid_reg && any_free;
    assign sts.scan_miss = n_zero || (chk_valid_reg && !any_free && chk_word_reg == last_word);
    assign sts.bad_addr  = diff_reg[AW] || (diff_reg[AW-1:0] >= AW'(limit_reg));
    assign sts.div_last  = 1'b1;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // ---------------- assertions ----------------
    a_hit_managed: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_wr |-> ({chk_word_reg, hit_bit} < n_reg))
        else $error("allocated page lies beyond the managed pages");

    a_hit_miss_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_run |-> !(sts.scan_hit && sts.scan_miss))
        else $error("scan reports a hit and a miss together");

    a_free_index: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.f_rd |-> (q_reg < n_reg))
        else $error("freed page index beyond the managed pages");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !cmd.out_load)
        else $error("result loaded over a stalled beat");

endmodule

`default_nettype wire

// ----- sv/bpfa_ctrl.sv -----
// Controller state machine of the bitmap page frame allocator.
`default_nettype none

module bpfa_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic           s_tuser,
    input  wire bpfa_pkg::sts_t sts,
    output bpfa_pkg::cmd_t      cmd
);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_SCAN  = 11'b00000000100,
        S_AMUL  = 11'b00000001000,
        S_AADD  = 11'b00000010000,
        S_FSUB  = 11'b00000100000,
        S_FCMP  = 11'b00001000000,
        S_FDIV  = 11'b00010000000,
        S_FRD   = 11'b00100000000,
        S_FWR   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = bpfa_pkg::ST_OK;
        if (sts.pc_write) begin
            // a new page count restarts the sweep from the first word
            state_next    = S_CLEAR;
            cmd.clr_start = 1'b1;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    cmd.clr_run = 1'b1;
                    if (sts.clr_last) begin
                        state_next = S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        cmd.load_req = 1'b1;
                        if (s_tuser == bpfa_pkg::REQ_ALLOC) begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end else begin
                            state_next = S_FSUB;
                        end
                    end
                end
                S_SCAN: begin
                    cmd.scan_run = 1'b1;
                    if (sts.scan_miss) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = bpfa_pkg::ST_OOM;
                        state_next     = S_OUT;
                    end else if (sts.scan_hit) begin
                        state_next = S_AMUL;
                    end
                end
                S_AMUL: begin
                    cmd.a_mul  = 1'b1;
                    state_next = S_AADD;
                end
                S_AADD: begin
                    cmd.a_add  = 1'b1;
                    state_next = S_OUT;
                end
                S_FSUB: begin
                    cmd.f_sub  = 1'b1;
                    state_next = S_FCMP;
                end
                S_FCMP: begin
                    if (sts.bad_addr) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = bpfa_pkg::ST_BADADDR;
                        state_next     = S_OUT;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = S_FDIV;
                    end
                end
                S_FDIV: begin
                    cmd.div_run = 1'b1;
                    if (sts.div_last) begin
                        state_next = S_FRD;
                    end
                end
                S_FRD: begin
                    cmd.f_rd   = 1'b1;
                    state_next = S_FWR;
                end
                S_FWR: begin
                    cmd.f_wr   = 1'b1;
                    state_next = S_OUT;
                end
                S_OUT: begin
                    if (sts.out_free) begin
                        cmd.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bitmap_page_frame_allocator_top.sv -----
// Top level of the first-fit bitmap page frame allocator.
// Allocate: first-fit scan, then page index times page size plus region base; the scan
//   reads one 32-bit bitmap word a cycle through the single memory read port.
// Free: offset from the base and range check; inside the region one reciprocal multiply gives the index.
// One request is in flight at a time; the next beat is taken the cycle after the result enters
//   the output register.
// Reset (aresetn, synchronous, active low) clears base and page count, then sweeps the bitmap
//   one word a cycle; a page_count write repeats that sweep.
`default_nettype none

module bitmap_page_frame_allocator_top #(
    parameter int MAX_PAGES  = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [47:0] free_address
    input  wire logic        s_tuser,   // [0] req_type
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [47:0] page_address
    output logic [1:0]       m_tuser,   // [1:0] status
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,  // 0 region_base, 1 page_count
    input  wire logic [47:0] cfg_data
);

    bpfa_pkg::cmd_t cmd;
    bpfa_pkg::sts_t sts;

    // Registers are always writable; writes are expected only while no request is in flight
    assign cfg_ready = 1'b1;

    // Sequencer: clearing sweep, first-fit scan, address build, range check, divide and bitmap update
    bpfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Bitmap memory, configuration registers, arithmetic and the output register
    bpfa_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ----- dv/bitmap_page_frame_allocator_top_test.sv -----
// Self-checking testbench of the first-fit bitmap page frame allocator.
module bitmap_page_frame_allocator_top_test;

    localparam int MAX_PAGES      = 1024;
    localparam int PAGE_BYTES     = 4096;
    // Longest correct quiet stretch: the long receiver hold-off, a clearing sweep and a
    // full-region scan, plus sender gaps; allow several times that.
    localparam int RX_HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 64;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_ITEMS    = 165;

    typedef struct packed {
        bpfa_pkg::status_t status;
        logic [47:0]       page_address;
    } page_outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // [47:0] free_address
    logic        s_tuser;    // [0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // [47:0] page_address
    logic [1:0]  m_tuser;    // [1:0] status
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [47:0] cfg_data;

    bitmap_page_frame_allocator_top #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the allocator: registers and one used bit per page
    logic [47:0] region_base_q;
    logic [10:0] page_count_q;
    bit          page_used [MAX_PAGES];

    page_outcome_t pending_outcomes_q[$];  // outcomes of accepted requests, oldest first
    logic [47:0]   live_pages_q[$];        // addresses handed out and not yet freed

    int mismatches;
    int n_alloc, n_free, n_cfg;
    int n_ok, n_oom, n_bad;
    int quiet_cycles;
    int burst_left;
    int rx_hold_asked;   // written by the stimulus only
    int rx_hold_seen;    // written by the receiver only

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int unsigned managed_pages();
        return (page_count_q > MAX_PAGES) ? MAX_PAGES : page_count_q;
    endfunction

    // Clear the map, then mark the pages that hold the bitmap itself as used.
    function automatic void rebuild_page_map();
        int unsigned map_bytes;
        int unsigned holding;
        map_bytes = (managed_pages() + 7) / 8;
        holding   = (map_bytes + PAGE_BYTES - 1) / PAGE_BYTES;
        if (holding > MAX_PAGES)
            holding = MAX_PAGES;
        foreach (page_used[i])
            page_used[i] = (i < holding);
    endfunction

    // Apply one request to the shadow map and return the result it must produce.
    function automatic page_outcome_t page_op_outcome(bpfa_pkg::req_t kind, logic [47:0] addr);
        page_outcome_t outcome;
        int unsigned   pages;
        logic [63:0]   offset;
        logic [63:0]   span;
        pages  = managed_pages();
        outcome.page_address = '0;
        if (kind == bpfa_pkg::REQ_ALLOC) begin
            outcome.status = bpfa_pkg::ST_OOM;
            for (int unsigned i = 0; i < pages; i++) begin
                if (!page_used[i]) begin
                    page_used[i] = 1'b1;
                    outcome.status = bpfa_pkg::ST_OK;
                    outcome.page_address = region_base_q + 48'(i) * 48'(PAGE_BYTES);
                    break;
                end
            end
        end else begin
            // compare the region end without wrapping at 48 bits
            span   = 64'(pages) * 64'(PAGE_BYTES);
            offset = 64'(addr) - 64'(region_base_q);
            if (addr < region_base_q || offset >= span) begin
                outcome.status = bpfa_pkg::ST_BADADDR;
            end else begin
                outcome.status = bpfa_pkg::ST_OK;
                page_used[offset / PAGE_BYTES] = 1'b0;
            end
        end
        return outcome;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    // ------------------------------------------------------------------
    // Drivers: inputs change on the falling edge, handshakes are seen on the rising edge
    // ------------------------------------------------------------------

    // Offer one request beat and hold it until taken. Valid stays high on return, so
    // back-to-back calls make a burst; pause_requests or drain_results lower it.
    task automatic send_request(bpfa_pkg::req_t kind, logic [47:0] addr);
        page_outcome_t outcome;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        outcome = page_op_outcome(kind, addr);
        pending_outcomes_q.push_back(outcome);
        if (kind == bpfa_pkg::REQ_ALLOC) begin
            n_alloc++;
            if (outcome.status == bpfa_pkg::ST_OK)
                live_pages_q.push_back(outcome.page_address);
        end else begin
            n_free++;
        end
    endtask

    task automatic pause_requests(int cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tdata  <= rand48();
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_outcomes_q.size() != 0) @(posedge aclk);
    endtask

    // Write one register; call only with the block drained.
    task automatic write_register(bpfa_pkg::cfg_index_t idx, logic [47:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == bpfa_pkg::CFG_REGION_BASE) begin
            region_base_q = data;
        end else begin
            page_count_q = data[10:0];
            rebuild_page_map();
            live_pages_q.delete();
        end
        n_cfg++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall on a changing pattern, with an occasional long hold-off
    // ------------------------------------------------------------------

    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        m_tready     = 1'b0;
        rx_hold_seen = 0;
        mode_left    = 0;
        hold_left    = 0;
        tick         = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_asked != rx_hold_seen) begin
                rx_hold_seen = rx_hold_asked;
                hold_left    = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(40, 300);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: m_tready <= 1'b1;                          // no stalls at all
                    1: m_tready <= ($urandom_range(0, 3) != 0);  // light random stalls
                    2: m_tready <= (tick % 4 == 0);              // ready only when tick is a multiple of 4
                    default: m_tready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        page_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            case (m_tuser)
                bpfa_pkg::ST_OK:      n_ok++;
                bpfa_pkg::ST_OOM:     n_oom++;
                bpfa_pkg::ST_BADADDR: n_bad++;
                default: ;
            endcase
            if (pending_outcomes_q.size() == 0) begin
                $error("result beat with no request outstanding: status %0d page_address %h",
                       m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = pending_outcomes_q.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata !== want.page_address) begin
                    $error("page_address mismatch: expected %h, got %h",
                           want.page_address, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nothing managed after reset: allocate runs out, every free is rejected.
    task automatic test_empty_region();
        send_request(bpfa_pkg::REQ_ALLOC, 48'hFFFF_FFFF_FFFF);
        send_request(bpfa_pkg::REQ_FREE, 48'h0);
        drain_results();
        write_register(bpfa_pkg::CFG_REGION_BASE, 48'h0000_0000_1000);
        send_request(bpfa_pkg::REQ_FREE, 48'h0000_0000_1000);
        drain_results();
    endtask

    // Four pages, page 0 holds the map. Junk above the count field must be dropped.
    task automatic test_small_region();
        logic [47:0] base;
        base = 48'h0000_7654_3000;
        write_register(bpfa_pkg::CFG_REGION_BASE, base);
        write_register(bpfa_pkg::CFG_PAGE_COUNT, 48'hABCD_E000_0004);
        repeat (4) send_request(bpfa_pkg::REQ_ALLOC, rand48());  // pages 1..3, then out of memory
        send_request(bpfa_pkg::REQ_FREE, base);                  // release the map-holding page
        send_request(bpfa_pkg::REQ_FREE, base + 48'h2000 + 48'hFFF);  // unaligned, page 2
        send_request(bpfa_pkg::REQ_FREE, base + 48'h2000);       // page already free
        send_request(bpfa_pkg::REQ_ALLOC, 48'h0);                // lowest free is page 0
        send_request(bpfa_pkg::REQ_ALLOC, 48'h0);
        drain_results();
    endtask

    // Addresses either side of both region bounds.
    task automatic test_region_edges();
        logic [47:0] base;
        base = region_base_q;
        send_request(bpfa_pkg::REQ_FREE, base - 48'd1);
        send_request(bpfa_pkg::REQ_FREE, base + 48'h4000);
        send_request(bpfa_pkg::REQ_FREE, base + 48'h4000 - 48'd1);
        send_request(bpfa_pkg::REQ_FREE, 48'h0);
        send_request(bpfa_pkg::REQ_ALLOC, 48'h0);
        drain_results();
    endtask

    // Region hanging over the top of the address space, saturated page count.
    task automatic test_top_of_address_space();
        write_register(bpfa_pkg::CFG_REGION_BASE, 48'hFFFF_FFFF_E000);
        write_register(bpfa_pkg::CFG_PAGE_COUNT, 48'h0000_0000_07FF);
        send_request(bpfa_pkg::REQ_ALLOC, 48'h0);              // last page below 2^48
        send_request(bpfa_pkg::REQ_ALLOC, 48'h0);              // wraps to address 0
        send_request(bpfa_pkg::REQ_FREE, 48'hFFFF_FFFF_FFFF);  // end is compared without wrap
        send_request(bpfa_pkg::REQ_FREE, 48'h0);               // below base, rejected
        send_request(bpfa_pkg::REQ_ALLOC, 48'h0);
        drain_results();
        write_register(bpfa_pkg::CFG_REGION_BASE, 48'hFFFF_FFFF_FFFF);
        write_register(bpfa_pkg::CFG_PAGE_COUNT, 48'h5555_5555_5001);
        send_request(bpfa_pkg::REQ_ALLOC, 48'h0);              // only page is the map: full
        send_request(bpfa_pkg::REQ_FREE, 48'hFFFF_FFFF_FFFF);
        send_request(bpfa_pkg::REQ_ALLOC, 48'h0);
        drain_results();
    endtask

    // Pick a fresh region for one random phase, registers in random order.
    task automatic configure_random_region();
        logic [47:0] base;
        logic [47:0] count_word;
        case ($urandom_range(0, 4))
            0: base = 48'h0;
            1: base = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 64)) * 48'(PAGE_BYTES);
            2: base = rand48() & 48'hFFFF_FFFF_F000;
            3: base = rand48();
            default: base = 48'($urandom_range(0, 1 << 24));
        endcase
        count_word = rand48();
        case ($urandom_range(0, 9))
            0: count_word[10:0] = 11'd0;
            1: count_word[10:0] = 11'd1024;
            2: count_word[10:0] = 11'($urandom_range(1025, 2047));
            3: count_word[10:0] = 11'($urandom_range(41, 1023));
            default: count_word[10:0] = 11'($urandom_range(1, 40));
        endcase
        if ($urandom_range(0, 1)) begin
            write_register(bpfa_pkg::CFG_REGION_BASE, base);
            write_register(bpfa_pkg::CFG_PAGE_COUNT, count_word);
        end else begin
            write_register(bpfa_pkg::CFG_PAGE_COUNT, count_word);
            write_register(bpfa_pkg::CFG_REGION_BASE, base);
        end
    endtask

    // Mostly allocate/free pairs on live pages, the rest stray and malformed frees.
    task automatic test_mixed_traffic();
        bit          steady;
        int          pick;
        int          j;
        int unsigned pages;
        logic [47:0] addr;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            configure_random_region();
            steady     = ($urandom_range(0, 3) == 0);   // some phases never idle
            burst_left = 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (burst_left == 0) begin
                    if (!steady)
                        pause_requests($urandom_range(1, 20));
                    burst_left = $urandom_range(1, 30);
                end
                burst_left--;
                pages = managed_pages();
                pick  = $urandom_range(0, 99);
                if (pick < 45) begin
                    send_request(bpfa_pkg::REQ_ALLOC, rand48());
                end else if (pick < 80 && live_pages_q.size() > 0) begin
                    j    = $urandom_range(0, live_pages_q.size() - 1);
                    addr = live_pages_q[j] + 48'($urandom_range(0, PAGE_BYTES - 1));
                    live_pages_q.delete(j);
                    send_request(bpfa_pkg::REQ_FREE, addr);
                end else if (pick < 88 && pages > 0) begin
                    // anywhere in the region, often a page already free
                    addr = region_base_q + 48'($urandom_range(0, pages * PAGE_BYTES - 1));
                    send_request(bpfa_pkg::REQ_FREE, addr);
                end else if (pick < 92) begin
                    send_request(bpfa_pkg::REQ_FREE,
                                 region_base_q - 48'($urandom_range(1, 1 << 20)));
                end else if (pick < 96) begin
                    addr = region_base_q + 48'(pages) * 48'(PAGE_BYTES)
                         + 48'($urandom_range(0, 1 << 20));
                    send_request(bpfa_pkg::REQ_FREE, addr);
                end else begin
                    send_request(bpfa_pkg::REQ_FREE, rand48());
                end
            end
        end
        drain_results();
    endtask

    // Hold the receiver off while requests keep coming, so the block backs up.
    task automatic test_result_backpressure();
        write_register(bpfa_pkg::CFG_REGION_BASE, rand48() & 48'hFFFF_FFFF_F000);
        write_register(bpfa_pkg::CFG_PAGE_COUNT, 48'h0000_0000_0008);
        rx_hold_asked++;
        for (int k = 0; k < 30; k++) begin
            if (k % 3 == 2 && live_pages_q.size() > 0)
                send_request(bpfa_pkg::REQ_FREE, live_pages_q.pop_front());
            else
                send_request(bpfa_pkg::REQ_ALLOC, rand48());
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = bpfa_pkg::REQ_ALLOC;
        cfg_valid     = 1'b0;
        cfg_index     = bpfa_pkg::CFG_REGION_BASE;
        cfg_data      = '0;
        rx_hold_asked = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        n_alloc = 0; n_free = 0; n_cfg = 0;
        n_ok = 0; n_oom = 0; n_bad = 0;
        region_base_q = '0;
        page_count_q  = '0;
        rebuild_page_map();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_region();
        test_small_region();
        test_region_edges();
        test_top_of_address_space();
        test_mixed_traffic();
        test_result_backpressure();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d allocate and %0d free requests across %0d register writes.",
                 n_alloc, n_free, n_cfg);
        $display("Returned %0d ok, %0d out of memory, %0d rejected free addresses.",
                 n_ok, n_oom, n_bad);
        if (mismatches == 0 && pending_outcomes_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/bpfa_pkg.sv
sv/bpfa_dp.sv
sv/bpfa_ctrl.sv
sv/bitmap_page_frame_allocator_top.sv
dv/bitmap_page_frame_allocator_top_test.sv
